// File: hdl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3 package
// constants and helper functions shared by the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // request kinds
   localparam logic REQ_BYTE   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   localparam logic [31:0] IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// File: hdl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// sm3 hash engine
// byte-serial sm3 hashing with one shared round unit
// ----------------------------------------------------------------------------
// Usage: each req_ word carries kind and data_byte. A message byte (kind 0)
// is packed into the 64-byte block buffer; the 64th byte of a block starts
// the compression, which runs one round per cycle for the 64 rounds and then
// folds into the chaining value, with req_stall high throughout. A finish
// word (kind 1) feeds padding bytes one per cycle between compressions
// (0x80, zeros, then the 64-bit length), compressing one or two blocks,
// then presents the eight digest words A..H on rsp_ with word_index and
// last_word. No message byte is taken while a block is compressed, so the
// sustained rate is set by the single round unit and the one-byte-per-cycle
// buffer write. The wait from a finish to the first digest word depends on
// the bytes left to pad and whether a second block is compressed.
// When rsp_stall is high the current digest word holds; the engine is not
// ready for new input until the last word is taken. Synchronous reset loads
// the IV, clears the length and byte position and empties the output.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sm3_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] blk_ff [16];
   logic [31:0] cv_ff [8];
   logic [31:0] r_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] flen_ff;
   logic [3:0]  padcnt_ff;      // length bytes emitted
   logic        padlen_ff;      // in the length-byte phase
   logic        fin_ff;         // compression belongs to a finish
   logic [5:0]  rnd_ff;
   logic [2:0]  oidx_ff;

   // byte to write this cycle
   logic        put;
   logic [7:0]  pbyte;
   logic        acc;

   assign acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      put = 1'b0;
      pbyte = req_data_byte;
      if (state_ff == ST_IDLE && acc && req_kind == REQ_BYTE) begin
         put = 1'b1;
      end else if (state_ff == ST_PAD) begin
         put = 1'b1;
         if (padlen_ff) pbyte = flen_ff[63:56];
         else if (padcnt_ff == 4'd0) pbyte = PAD_BYTE;
         else pbyte = 8'h00;
      end
   end

   // round datapath
   logic [31:0] a12, ss1, ss2, ff_v, gg_v, tt1, tt2, tj, wj, wj4, nw;
   logic [3:0]  j;
   always_comb begin
      j = rnd_ff[3:0];
      wj  = w_ff[j];
      wj4 = w_ff[j + 4'd4];
      tj  = rotl((rnd_ff < 6'd16) ? T_LOW : T_HIGH, rnd_ff[4:0]);
      a12 = rotl(r_ff[0], 5'd12);
      ss1 = rotl(a12 + r_ff[4] + tj, 5'd7);
      ss2 = ss1 ^ a12;
      if (rnd_ff < 6'd16) begin
         ff_v = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg_v = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff_v = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg_v = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ff_v + r_ff[3] + ss2 + (wj ^ wj4);
      tt2 = gg_v + r_ff[7] + ss1 + wj;
      nw = perm1(wj ^ w_ff[j + 4'd7] ^ rotl(w_ff[j + 4'd13], 5'd15))
           ^ rotl(w_ff[j + 4'd3], 5'd7) ^ w_ff[j + 4'd10];
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      if (put) pos_in = pos_ff + 6'd1;
      case (state_ff)
         ST_IDLE: begin
            if (acc && req_kind == REQ_BYTE) begin
               len_in = len_ff + 64'd8;
               if (pos_ff == 6'd63) state_in = ST_RND;
            end else if (acc) begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (pos_ff == 6'd63) state_in = ST_RND;
         end
         ST_RND: begin
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (!fin_ff) state_in = ST_IDLE;
            else if (padcnt_ff == 4'd8) state_in = ST_OUT;
            else state_in = ST_PAD;
         end
         ST_OUT: begin
            if (!rsp_stall && oidx_ff == 3'd7) begin
               state_in = ST_IDLE;
               len_in = 64'd0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         len_ff <= '0;
         fin_ff <= 1'b0;
         padcnt_ff <= '0;
         padlen_ff <= 1'b0;
         rnd_ff <= '0;
         oidx_ff <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= IV[i];
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         if (state_ff == ST_IDLE && acc && req_kind == REQ_FINISH) begin
            fin_ff <= 1'b1;
            padcnt_ff <= '0;
            padlen_ff <= 1'b0;
            flen_ff <= len_ff;
         end
         if (state_ff == ST_PAD) begin
            // padcnt counts the 0x80 byte then, in length phase, length bytes
            if (padlen_ff) begin
               padcnt_ff <= padcnt_ff + 4'd1;
               flen_ff <= {flen_ff[55:0], 8'h00};
            end else if (pos_ff == 6'd55) begin
               padlen_ff <= 1'b1;
               padcnt_ff <= '0;
            end else begin
               padcnt_ff <= 4'd1;
            end
         end
         if (state_ff == ST_RND) rnd_ff <= rnd_ff + 6'd1;
         else rnd_ff <= '0;
         if (state_ff == ST_FOLD) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] ^ r_ff[i];
         end
         if (state_ff == ST_OUT && !rsp_stall) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               fin_ff <= 1'b0;
               for (int i = 0; i < 8; i++) cv_ff[i] <= IV[i];
            end
         end
      end
   end

   // payload: block buffer, round registers, expansion window
   always_ff @(posedge clock) begin
      if (put) begin
         if (pos_ff[1:0] == 2'd0)
            blk_ff[pos_ff[5:2]] <= {pbyte, 24'd0};
         else
            blk_ff[pos_ff[5:2]] <= blk_ff[pos_ff[5:2]]
                                   | ({24'd0, pbyte} << {~pos_ff[1:0], 3'd0});
      end
      if (state_ff == ST_RND) begin
         r_ff[3] <= r_ff[2];
         r_ff[2] <= rotl(r_ff[1], 5'd9);
         r_ff[1] <= r_ff[0];
         r_ff[0] <= tt1;
         r_ff[7] <= r_ff[6];
         r_ff[6] <= rotl(r_ff[5], 5'd19);
         r_ff[5] <= r_ff[4];
         r_ff[4] <= perm0(tt2);
         w_ff[j] <= nw;
      end else begin
         // load window and working registers ahead of the rounds
         for (int i = 0; i < 8; i++) r_ff[i] <= cv_ff[i];
         for (int i = 0; i < 15; i++) w_ff[i] <= blk_ff[i];
         // the last byte of a block lands in the window directly
         if (put && pos_ff == 6'd63)
            w_ff[15] <= blk_ff[15] | {24'd0, pbyte};
         else
            w_ff[15] <= blk_ff[15];
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_digest_word = cv_ff[oidx_ff];
   assign rsp_word_index = oidx_ff;
   assign rsp_last_word = (oidx_ff == 3'd7);

endmodule

// File: verif/sm3_hash_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sm3 hash checker
// watches both channels, predicts the digest of every finished message and
// compares each digest word against the oldest predicted word
// ----------------------------------------------------------------------------
module sm3_hash_checker
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          pending_words
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic [31:0]     chain_v [8];
   logic [31:0]     block_w [16];
   logic [5:0]      byte_pos;
   logic [63:0]     bit_len;
   digest_word_type digest_q [$];

   function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} << (n % 32);
      return d[63:32];
   endfunction

   task automatic compress_block();
      logic [31:0] r [8];
      logic [31:0] w [16];
      logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, nw, wj, wj4;
      for (int i = 0; i < 16; i++) w[i] = block_w[i];
      for (int i = 0; i < 8; i++) r[i] = chain_v[i];
      for (int j = 0; j < 64; j++) begin
         wj  = w[j % 16];
         wj4 = w[(j + 4) % 16];
         t   = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
         a12 = rot_left(r[0], 12);
         ss1 = rot_left(a12 + r[4] + rot_left(t, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = r[0] ^ r[1] ^ r[2];
            gg = r[4] ^ r[5] ^ r[6];
         end else begin
            ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            gg = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ff + r[3] + ss2 + (wj ^ wj4);
         tt2 = gg + r[7] + ss1 + wj;
         r[3] = r[2];
         r[2] = rot_left(r[1], 9);
         r[1] = r[0];
         r[0] = tt1;
         r[7] = r[6];
         r[6] = rot_left(r[5], 19);
         r[5] = r[4];
         r[4] = tt2 ^ rot_left(tt2, 9) ^ rot_left(tt2, 17);
         nw = wj ^ w[(j + 7) % 16] ^ rot_left(w[(j + 13) % 16], 15);
         nw = nw ^ rot_left(nw, 15) ^ rot_left(nw, 23);
         w[j % 16] = nw ^ rot_left(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
      end
      for (int i = 0; i < 8; i++) chain_v[i] ^= r[i];
   endtask

   task automatic push_byte(input logic [7:0] b);
      if (byte_pos[1:0] == 2'd0) block_w[byte_pos[5:2]] = {b, 24'h0};
      else block_w[byte_pos[5:2]] |= 32'(b) << ((3 - byte_pos[1:0]) * 8);
      byte_pos = byte_pos + 6'd1;
      if (byte_pos == 6'd0) compress_block();
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_v[i] = IV[i];
      for (int i = 0; i < 16; i++) block_w[i] = '0;
      byte_pos = '0;
      bit_len  = '0;
   endtask

   task automatic finish_message();
      logic [63:0] len;
      len = bit_len;
      push_byte(PAD_BYTE);
      while (byte_pos != 6'd56) push_byte(8'h00);
      for (int k = 7; k >= 0; k--) push_byte(len[8*k +: 8]);
      for (int k = 0; k < 8; k++)
         digest_q.push_back('{chain_v[k], 3'(k), k == 7});
      restart_message();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_words = 0;
      restart_message();
   end

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         restart_message();
         digest_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_digest_word, '0);
            end else begin
               exp_w = digest_q.pop_front();
               if (rsp_digest_word !== exp_w.digest_word)
                  report_mismatch("digest_word", rsp_digest_word, exp_w.digest_word);
               if (rsp_word_index !== exp_w.word_index)
                  report_mismatch("word_index", 32'(rsp_word_index), 32'(exp_w.word_index));
               if (rsp_last_word !== exp_w.last_word)
                  report_mismatch("last_word", 32'(rsp_last_word), 32'(exp_w.last_word));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == REQ_BYTE) begin
               bit_len = bit_len + 64'd8;
               push_byte(req_data_byte);
            end else begin
               finish_message();
            end
         end
      end
      pending_words = digest_q.size();
   end

endmodule

// File: verif/tb_sm3_hash_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sm3 hash engine testbench
// drives messages of varied length with random idling on both channels;
// the checker predicts every digest and compares it word by word
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine;
   import sm3_pkg::*;

   localparam int   CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = REQ_BYTE;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count;
   int          pending_words;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off = 0;
   longint      cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sm3_hash_engine u_dut (.*);

   sm3_hash_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] b);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_word(REQ_BYTE, 8'($urandom));
      send_word(REQ_FINISH, 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extreme bytes, finish with all-ones byte
      send_word(REQ_FINISH, 8'h00);
      send_word(REQ_FINISH, 8'hff);
      send_word(REQ_BYTE, 8'h00);
      send_word(REQ_BYTE, 8'hff);
      send_word(REQ_BYTE, 8'haa);
      send_word(REQ_BYTE, 8'h55);
      send_word(REQ_FINISH, 8'h00);
      send_word(REQ_BYTE, 8'h61);
      send_word(REQ_BYTE, 8'h62);
      send_word(REQ_BYTE, 8'h63);
      send_word(REQ_FINISH, 8'h00);
      drain();

      // receiver holds off long while messages keep coming
      hold_off = 3000;
      send_message(3);
      send_message(0);
      send_message(5);
      drain();

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int m = 0; m < 2; m++) begin
            // lengths around the padding boundaries and block multiples
            case ($urandom_range(3))
               0: len = $urandom_range(20);
               1: len = 52 + $urandom_range(15);
               2: len = 64 * $urandom_range(1, 2) - 1 + $urandom_range(2);
               default: len = $urandom_range(130);
            endcase
            send_message(len);
            sent += len + 1;
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
hdl/sm3_pkg.sv
hdl/sm3_hash_engine.sv
verif/sm3_hash_checker.sv
verif/tb_sm3_hash_engine.sv
